/* src/json_stream_tokenizer_assert.svh */
// Assertion macros for the tokenizer top module; clk and rst must be in scope.
`ifndef JSON_STREAM_TOKENIZER_ASSERT_SVH
`define JSON_STREAM_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, checked outside reset.
`define JST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

/* src/jst_pkg.sv */
// Types, character codes and keyword tables for the JSON stream tokenizer.
package jst_pkg;

  // Default width of the signed brace and bracket balances.
  localparam int JST_COUNT_WIDTH = 16;

  // Result queue depth and its pointer widths.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;

  // Input item kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [3:0] {
    EV_STR_BYTE   = 4'd0,
    EV_NUM_BYTE   = 4'd1,
    EV_STR_END    = 4'd2,
    EV_INT_END    = 4'd3,
    EV_DBL_END    = 4'd4,
    EV_COMMA      = 4'd5,
    EV_LBRACE     = 4'd6,
    EV_RBRACE     = 4'd7,
    EV_LBRACK     = 4'd8,
    EV_RBRACK     = 4'd9,
    EV_COLON      = 4'd10,
    EV_TRUE       = 4'd11,
    EV_FALSE      = 4'd12,
    EV_NULL       = 4'd13,
    EV_DOC_OK     = 4'd14,
    EV_DOC_BAD    = 4'd15
  } event_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_KW   = 2'd3
  } lex_mode_t;

  typedef enum logic [1:0] {
    KW_TRUE  = 2'd0,
    KW_FALSE = 2'd1,
    KW_NULL  = 2'd2
  } kw_sel_t;

  // One result word as it sits in the output queue.
  typedef struct packed {
    event_t     ev;
    logic [7:0] payload;
    logic       last;
  } jst_word_t;

  // Up to two result words produced by one input item.
  typedef struct packed {
    logic      v0;
    logic      v1;
    jst_word_t w0;
    jst_word_t w1;
  } jst_push_t;

  // Expected letter of a keyword at a given position.
  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      KW_TRUE: begin
        case (pos)
          3'd0: c = 8'h74;
          3'd1: c = 8'h72;
          3'd2: c = 8'h75;
          3'd3: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0: c = 8'h66;
          3'd1: c = 8'h61;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h73;
          3'd4: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      KW_NULL: begin
        case (pos)
          3'd0: c = 8'h6E;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Keyword length; zero for a selector that names no keyword.
  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    logic [2:0] n;
    case (sel)
      KW_TRUE:  n = 3'd4;
      KW_FALSE: n = 3'd5;
      KW_NULL:  n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // Event for a completed keyword.
  function automatic event_t kw_event(input logic [1:0] sel);
    event_t e;
    case (sel)
      KW_TRUE:  e = EV_TRUE;
      KW_FALSE: e = EV_FALSE;
      default:  e = EV_NULL;
    endcase
    return e;
  endfunction

endpackage

/* src/jst_lexer.sv */
// Lexer state and the per-byte token decision for the JSON stream tokenizer.
module jst_lexer #(
  parameter int COUNT_WIDTH = jst_pkg::JST_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                kind,
  input  logic [7:0]          text_byte,
  output jst_pkg::jst_push_t  push
);
  import jst_pkg::*;

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_ZERO = '0;

  lex_mode_t                      mode, mode_next;
  logic                           prev_bs, prev_bs_next;
  logic                           has_dot, has_dot_next;
  logic [1:0]                     kw_sel, kw_sel_next;
  logic [2:0]                     kw_pos, kw_pos_next;
  logic signed [COUNT_WIDTH-1:0]  brace, brace_next;
  logic signed [COUNT_WIDTH-1:0]  bracket, bracket_next;

  // Decision signals: a first word from the current mode, then the idle handling.
  logic       term_v;
  event_t     term_ev;
  logic [7:0] term_pay;
  logic       idle_run;
  logic       idle_v;
  event_t     idle_ev;
  logic [7:0] idle_pay;
  logic       is_digit;
  logic [2:0] pos_inc;

  assign is_digit = (text_byte inside {[CH_ZERO:CH_NINE]});
  assign pos_inc  = kw_pos + 3'd1;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      prev_bs <= 1'b0;
      has_dot <= 1'b0;
      kw_sel  <= KW_TRUE;
      kw_pos  <= 3'd0;
      brace   <= CNT_ZERO;
      bracket <= CNT_ZERO;
    end else if (take) begin
      mode    <= mode_next;
      prev_bs <= prev_bs_next;
      has_dot <= has_dot_next;
      kw_sel  <= kw_sel_next;
      kw_pos  <= kw_pos_next;
      brace   <= brace_next;
      bracket <= bracket_next;
    end
  end

  // Token decision for one input word.
  always_comb begin
    mode_next    = mode;
    prev_bs_next = prev_bs;
    has_dot_next = has_dot;
    kw_sel_next  = kw_sel;
    kw_pos_next  = kw_pos;
    brace_next   = brace;
    bracket_next = bracket;
    term_v       = 1'b0;
    term_ev      = EV_STR_BYTE;
    term_pay     = 8'h00;
    idle_run     = 1'b0;
    idle_v       = 1'b0;
    idle_ev      = EV_STR_BYTE;
    idle_pay     = 8'h00;

    if (kind == KIND_END) begin
      // Close any open string or number, report the balance, clear all state.
      if (mode == MODE_STR) begin
        term_v  = 1'b1;
        term_ev = EV_STR_END;
      end else if (mode == MODE_NUM) begin
        term_v  = 1'b1;
        term_ev = has_dot ? EV_DBL_END : EV_INT_END;
      end
      idle_v       = 1'b1;
      idle_ev      = (brace == CNT_ZERO && bracket == CNT_ZERO) ? EV_DOC_OK : EV_DOC_BAD;
      mode_next    = MODE_IDLE;
      prev_bs_next = 1'b0;
      has_dot_next = 1'b0;
      kw_sel_next  = KW_TRUE;
      kw_pos_next  = 3'd0;
      brace_next   = CNT_ZERO;
      bracket_next = CNT_ZERO;
    end else begin
      case (mode)
        MODE_STR: begin
          if (text_byte == CH_QUOTE && !prev_bs) begin
            mode_next    = MODE_IDLE;
            prev_bs_next = 1'b0;
            term_v       = 1'b1;
            term_ev      = EV_STR_END;
          end else begin
            prev_bs_next = (text_byte == CH_BSLASH);
            term_v       = 1'b1;
            term_ev      = EV_STR_BYTE;
            term_pay     = text_byte;
          end
        end
        MODE_NUM: begin
          if (is_digit || text_byte == CH_DOT) begin
            if (text_byte == CH_DOT) begin
              has_dot_next = 1'b1;
            end
            term_v   = 1'b1;
            term_ev  = EV_NUM_BYTE;
            term_pay = text_byte;
          end else begin
            // The terminating byte is handled again as an idle byte.
            term_v       = 1'b1;
            term_ev      = has_dot ? EV_DBL_END : EV_INT_END;
            mode_next    = MODE_IDLE;
            has_dot_next = 1'b0;
            idle_run     = 1'b1;
          end
        end
        MODE_KW: begin
          if (kw_pos < kw_len(kw_sel) && text_byte == kw_char(kw_sel, kw_pos)) begin
            if (pos_inc >= kw_len(kw_sel)) begin
              mode_next   = MODE_IDLE;
              kw_sel_next = KW_TRUE;
              kw_pos_next = 3'd0;
              term_v      = 1'b1;
              term_ev     = kw_event(kw_sel);
            end else begin
              kw_pos_next = pos_inc;
            end
          end else begin
            // Mismatch drops the partial word and retries the byte in idle.
            mode_next   = MODE_IDLE;
            kw_sel_next = KW_TRUE;
            kw_pos_next = 3'd0;
            idle_run    = 1'b1;
          end
        end
        default: begin
          idle_run = 1'b1;
        end
      endcase

      // Idle byte handling.
      if (idle_run) begin
        case (text_byte)
          CH_QUOTE: begin
            mode_next    = MODE_STR;
            prev_bs_next = 1'b0;
          end
          CH_COMMA: begin
            idle_v  = 1'b1;
            idle_ev = EV_COMMA;
          end
          CH_LBRACE: begin
            idle_v     = 1'b1;
            idle_ev    = EV_LBRACE;
            brace_next = (brace == CNT_MAX) ? brace : brace + CNT_ONE;
          end
          CH_RBRACE: begin
            idle_v     = 1'b1;
            idle_ev    = EV_RBRACE;
            brace_next = (brace == CNT_MIN) ? brace : brace - CNT_ONE;
          end
          CH_LBRACK: begin
            idle_v       = 1'b1;
            idle_ev      = EV_LBRACK;
            bracket_next = (bracket == CNT_MAX) ? bracket : bracket + CNT_ONE;
          end
          CH_RBRACK: begin
            idle_v       = 1'b1;
            idle_ev      = EV_RBRACK;
            bracket_next = (bracket == CNT_MIN) ? bracket : bracket - CNT_ONE;
          end
          CH_COLON: begin
            idle_v  = 1'b1;
            idle_ev = EV_COLON;
          end
          CH_LOW_T: begin
            mode_next   = MODE_KW;
            kw_sel_next = KW_TRUE;
            kw_pos_next = 3'd1;
          end
          CH_LOW_F: begin
            mode_next   = MODE_KW;
            kw_sel_next = KW_FALSE;
            kw_pos_next = 3'd1;
          end
          CH_LOW_N: begin
            mode_next   = MODE_KW;
            kw_sel_next = KW_NULL;
            kw_pos_next = 3'd1;
          end
          default: begin
            if (text_byte == CH_MINUS || is_digit) begin
              mode_next    = MODE_NUM;
              has_dot_next = 1'b0;
              idle_v       = 1'b1;
              idle_ev      = EV_NUM_BYTE;
              idle_pay     = text_byte;
            end
          end
        endcase
      end
    end
  end

  // Pack the words in order; the last one carries the end-of-run mark.
  always_comb begin
    push = '0;
    if (term_v) begin
      push.v0         = 1'b1;
      push.w0.ev      = term_ev;
      push.w0.payload = term_pay;
      push.w0.last    = !idle_v;
      push.v1         = idle_v;
      push.w1.ev      = idle_ev;
      push.w1.payload = idle_pay;
      push.w1.last    = 1'b1;
    end else begin
      push.v0         = idle_v;
      push.w0.ev      = idle_ev;
      push.w0.payload = idle_pay;
      push.w0.last    = 1'b1;
      push.v1         = 1'b0;
      push.w1         = '0;
    end
  end

endmodule

/* src/json_stream_tokenizer.sv */
// Usage notes for the JSON stream tokenizer:
// The text channel (text_valid, text_stall, kind, text_byte) carries one word per
// JSON byte, or an end-of-document word when kind is high. The token channel
// (token_valid, token_stall, event_res, payload_byte, last_of_run) carries token
// events; last_of_run marks the final event caused by one text word, and a text
// word may cause zero, one or two events.
// A text word is decoded in the cycle it is accepted: lexer state updates at that
// edge and its events enter a four-word output queue, so the first event is
// visible in the cycle after acceptance.
// Throughput is one text word per cycle while the receiver keeps up and each word
// yields at most one event; a word yielding two events puts both in the queue, and
// the queue absorbs the difference until it holds three words, when text_stall
// rises. text_stall depends only on the queue fill level.
// While token_stall is high the head event holds steady and the queue fills.
// Synchronous reset clears the lexer state, both balances and the queue.
// An end-of-document word closes any open string or number, reports whether the
// brace and bracket balances are both zero, and returns the lexer to reset state.
module json_stream_tokenizer #(
  parameter int COUNT_WIDTH = jst_pkg::JST_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_stall,
  input  logic                kind,
  input  logic [7:0]          text_byte,
  output logic                token_valid,
  input  logic                token_stall,
  output jst_pkg::event_t     event_res,
  output logic [7:0]          payload_byte,
  output logic                last_of_run
);
  import jst_pkg::*;

  `include "json_stream_tokenizer_assert.svh"

  logic              take;
  logic              pop;
  jst_push_t         push;
  jst_word_t         queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic [QPTR_W-1:0] wr_ptr_next;
  logic [QCNT_W-1:0] push_n;
  jst_word_t         head;

  // Accept only while two queue slots are free.
  assign text_stall = (count > QCNT_W'(QDEPTH - 2));
  assign take       = text_valid && !text_stall;
  assign pop        = token_valid && !token_stall;

  jst_lexer #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .kind      (kind),
    .text_byte (text_byte),
    .push      (push)
  );

  // Queue bookkeeping.
  always_comb begin
    push_n      = take ? (QCNT_W'(push.v0) + QCNT_W'(push.v1)) : '0;
    wr_ptr_next = wr_ptr + push_n[QPTR_W-1:0];
    count_next  = count + push_n - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  // Queue storage: the first word goes at the write pointer, the second after it.
  always_ff @(posedge clk) begin
    if (take && push.v0) begin
      queue[wr_ptr] <= push.w0;
    end
    if (take && push.v1) begin
      queue[wr_ptr + QPTR_W'(1)] <= push.w1;
    end
  end

  // Head of the queue drives the token channel.
  assign head         = queue[rd_ptr];
  assign token_valid  = (count != '0);
  assign event_res    = head.ev;
  assign payload_byte = head.payload;
  assign last_of_run  = head.last;

  // The fill level never passes the queue depth.
  `JST_ASSERT_NOW(a_count_bound, 1'b1, count <= QCNT_W'(QDEPTH))
  // A word that is not last in its run always has its partner queued behind it.
  `JST_ASSERT_NOW(a_run_partner, token_valid && !last_of_run, count >= QCNT_W'(2))
  // A second word is never produced without a first one.
  `JST_ASSERT_NOW(a_push_order, take && push.v1, push.v0)
  // End of document always yields its closing report.
  `JST_ASSERT_NOW(a_doc_report, take && kind == KIND_END, push.v0)
  // A queued word shows up on the token channel in the next cycle.
  `JST_ASSERT_NEXT(a_push_visible, take && push.v0, token_valid)

endmodule

/* bench/json_stream_tokenizer_test.sv */
// Self-checking testbench for the JSON stream tokenizer: random bursty traffic, predicted tokens.
module json_stream_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jst_pkg::*;

  // Four-bit balance counters, so that saturation is reached within a few words.
  localparam int CNT_W = 4;
  localparam logic signed [CNT_W-1:0] BAL_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] BAL_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  localparam int TEXT_WORDS = 1000;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_AT = 600;
  localparam int HOLD_LEN = 80;

  typedef struct packed {
    logic       kind;
    logic [7:0] b;
  } text_word_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic text_valid = 1'b0;
  logic text_stall;
  logic kind = KIND_TEXT;
  logic [7:0] text_byte = 8'h00;
  logic token_valid;
  logic token_stall = 1'b0;
  event_t event_res;
  logic [7:0] payload_byte;
  logic last_of_run;

  json_stream_tokenizer #(.COUNT_WIDTH(CNT_W)) dut (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_stall(text_stall),
    .kind(kind),
    .text_byte(text_byte),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .event_res(event_res),
    .payload_byte(payload_byte),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lexer state as the tokenizer should hold it.
  lex_mode_t lx_mode = MODE_IDLE;
  logic esc_prev = 1'b0;
  logic num_dot = 1'b0;
  kw_sel_t kw_sel = KW_TRUE;
  logic [2:0] kw_pos = 3'd0;
  logic signed [CNT_W-1:0] brace_bal = '0;
  logic signed [CNT_W-1:0] brack_bal = '0;

  string kw_spell [3] = '{"true", "false", "null"};
  event_t kw_done [3] = '{EV_TRUE, EV_FALSE, EV_NULL};

  jst_word_t tok_run[$];
  jst_word_t expected_tokens[$];
  text_word_t text_backlog[$];
  int busy_words = 0;
  int fail_count = 0;

  function automatic logic signed [CNT_W-1:0] bal_step(input logic signed [CNT_W-1:0] v,
                                                       input logic up);
    if (up) begin
      return (v == BAL_MAX) ? v : CNT_W'(v + 1);
    end
    return (v == BAL_MIN) ? v : CNT_W'(v - 1);
  endfunction

  function void add_tok(input event_t e, input logic [7:0] p);
    jst_word_t w;
    w.ev = e;
    w.payload = p;
    w.last = 1'b0;
    tok_run = {tok_run, w};
  endfunction

  // A byte seen with no token open: punctuation, or the start of a token.
  function void lex_idle(input logic [7:0] b);
    if (b == CH_QUOTE) begin
      lx_mode = MODE_STR;
      esc_prev = 1'b0;
    end else if (b == CH_COMMA) begin
      add_tok(EV_COMMA, 8'h00);
    end else if (b == CH_LBRACE) begin
      brace_bal = bal_step(brace_bal, 1'b1);
      add_tok(EV_LBRACE, 8'h00);
    end else if (b == CH_RBRACE) begin
      brace_bal = bal_step(brace_bal, 1'b0);
      add_tok(EV_RBRACE, 8'h00);
    end else if (b == CH_LBRACK) begin
      brack_bal = bal_step(brack_bal, 1'b1);
      add_tok(EV_LBRACK, 8'h00);
    end else if (b == CH_RBRACK) begin
      brack_bal = bal_step(brack_bal, 1'b0);
      add_tok(EV_RBRACK, 8'h00);
    end else if (b == CH_COLON) begin
      add_tok(EV_COLON, 8'h00);
    end else if (b == CH_LOW_T || b == CH_LOW_F || b == CH_LOW_N) begin
      lx_mode = MODE_KW;
      kw_sel = (b == CH_LOW_T) ? KW_TRUE : (b == CH_LOW_F) ? KW_FALSE : KW_NULL;
      kw_pos = 3'd1;
    end else if (b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE)) begin
      lx_mode = MODE_NUM;
      num_dot = 1'b0;
      add_tok(EV_NUM_BYTE, b);
    end
  endfunction

  // Works out the tokens that one accepted text word causes and queues them.
  function void lex_word(input logic k, input logic [7:0] b);
    string spell;
    tok_run.delete();
    if (k == KIND_END) begin
      if (lx_mode == MODE_STR) begin
        add_tok(EV_STR_END, 8'h00);
      end else if (lx_mode == MODE_NUM) begin
        add_tok(num_dot ? EV_DBL_END : EV_INT_END, 8'h00);
      end
      add_tok((brace_bal == 0 && brack_bal == 0) ? EV_DOC_OK : EV_DOC_BAD, 8'h00);
      lx_mode = MODE_IDLE;
      esc_prev = 1'b0;
      num_dot = 1'b0;
      kw_sel = KW_TRUE;
      kw_pos = 3'd0;
      brace_bal = '0;
      brack_bal = '0;
    end else begin
      case (lx_mode)
        MODE_STR: begin
          // A quote after any backslash stays inside the string.
          if (b == CH_QUOTE && !esc_prev) begin
            lx_mode = MODE_IDLE;
            esc_prev = 1'b0;
            add_tok(EV_STR_END, 8'h00);
          end else begin
            esc_prev = (b == CH_BSLASH);
            add_tok(EV_STR_BYTE, b);
          end
        end
        MODE_NUM: begin
          if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT) begin
            if (b == CH_DOT) begin
              num_dot = 1'b1;
            end
            add_tok(EV_NUM_BYTE, b);
          end else begin
            // The terminating byte is looked at again with no token open.
            add_tok(num_dot ? EV_DBL_END : EV_INT_END, 8'h00);
            lx_mode = MODE_IDLE;
            num_dot = 1'b0;
            lex_idle(b);
          end
        end
        MODE_KW: begin
          spell = kw_spell[kw_sel];
          if (kw_pos < spell.len() && b == spell[kw_pos]) begin
            if (kw_pos + 1 == spell.len()) begin
              add_tok(kw_done[kw_sel], 8'h00);
              lx_mode = MODE_IDLE;
              kw_pos = 3'd0;
              kw_sel = KW_TRUE;
            end else begin
              kw_pos = kw_pos + 3'd1;
            end
          end else begin
            lx_mode = MODE_IDLE;
            kw_pos = 3'd0;
            kw_sel = KW_TRUE;
            lex_idle(b);
          end
        end
        default: begin
          lex_idle(b);
        end
      endcase
    end
    if (tok_run.size() > 0) begin
      tok_run[$].last = 1'b1;
    end
    foreach (tok_run[i]) begin
      expected_tokens = {expected_tokens, tok_run[i]};
    end
  endfunction

  // Stimulus builders. Every word offered to the block is counted.
  function automatic void put_byte(input logic [7:0] b);
    text_word_t w;
    w.kind = KIND_TEXT;
    w.b = b;
    text_backlog = {text_backlog, w};
    busy_words++;
  endfunction

  function automatic void put_text(input string s);
    foreach (s[i]) begin
      put_byte(s[i]);
    end
  endfunction

  function automatic void put_end();
    text_word_t w;
    w.kind = KIND_END;
    w.b = 8'($urandom_range(0, 255));
    text_backlog = {text_backlog, w};
    busy_words++;
  endfunction

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void put_space();
    repeat ($urandom_range(0, 2)) begin
      put_byte(pick(" \t\n\r"));
    end
  endfunction

  function automatic void put_string_tok();
    put_byte(CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0: begin
          put_byte(CH_BSLASH);
          put_byte(CH_QUOTE);
        end
        1: begin
          put_byte(CH_BSLASH);
          put_byte(CH_BSLASH);
        end
        2: put_byte(8'($urandom_range(0, 255)));
        default: put_byte(pick("abcxyzAZ 019{}[],:-.tfn"));
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      put_byte(CH_QUOTE);
    end
  endfunction

  function automatic void put_number();
    if ($urandom_range(0, 2) == 0) begin
      put_byte(CH_MINUS);
    end else begin
      put_byte(pick("0123456789"));
    end
    repeat ($urandom_range(0, 5)) begin
      put_byte(pick("0123456789."));
    end
  endfunction

  function automatic void put_keyword();
    string word;
    int cut;
    word = kw_spell[$urandom_range(0, 2)];
    if ($urandom_range(0, 4) != 0) begin
      put_text(word);
    end else begin
      // Broken keyword: a prefix, then a byte that may start something else.
      cut = $urandom_range(1, word.len() - 1);
      for (int i = 0; i < cut; i++) begin
        put_byte(word[i]);
      end
      put_byte(pick("xtfn\"{[,:-5 e"));
    end
  endfunction

  // A JSON-shaped value with random content; its strings, numbers and keywords may be malformed.
  function automatic void gen_value(input int depth);
    int members;
    case ($urandom_range(0, (depth < 3) ? 5 : 2))
      0: put_string_tok();
      1: put_number();
      2: put_keyword();
      3: begin
        put_byte(CH_LBRACE);
        members = $urandom_range(0, 3);
        for (int i = 0; i < members; i++) begin
          if (i > 0) begin
            put_byte(CH_COMMA);
          end
          put_space();
          put_string_tok();
          put_byte(CH_COLON);
          put_space();
          gen_value(depth + 1);
        end
        put_byte(CH_RBRACE);
      end
      default: begin
        put_byte(CH_LBRACK);
        members = $urandom_range(0, 3);
        for (int i = 0; i < members; i++) begin
          if (i > 0) begin
            put_byte(CH_COMMA);
          end
          put_space();
          gen_value(depth + 1);
        end
        put_byte(CH_RBRACK);
      end
    endcase
  endfunction

  // Loose pieces of text in any order, including long runs of one bracket.
  function automatic void gen_fragment();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: put_string_tok();
      1: put_number();
      2: put_keyword();
      3: put_byte(pick(",{}[]:"));
      4: put_space();
      5: put_byte(8'($urandom_range(0, 255)));
      6: begin
        c = pick("{}[]");
        repeat ($urandom_range(5, 12)) begin
          put_byte(c);
        end
      end
      default: gen_value(1);
    endcase
  endfunction

  // Driver: bursts of words with random gaps; the word on offer holds while stalled.
  text_word_t word_out;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && !text_stall) begin
        lex_word(kind, text_byte);
      end
      if (!text_valid || !text_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          text_valid <= 1'b0;
        end else if (text_backlog.size() > 0) begin
          word_out = text_backlog.pop_front();
          text_valid <= 1'b1;
          kind <= word_out.kind;
          text_byte <= word_out.b;
          if (burst_left > 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall style changes now and then, plus one long hold-off.
  rx_style_t rx_style = RX_FREE;
  int rx_cycle = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == HOLD_AT) begin
        hold_left = HOLD_LEN;
      end
      if (rx_cycle % 40 == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
      end
      if (hold_left > 0) begin
        hold_left--;
        token_stall <= 1'b1;
      end else begin
        case (rx_style)
          RX_FREE: token_stall <= 1'b0;
          RX_LIGHT: token_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: token_stall <= ($urandom_range(0, 3) != 0);
          default: token_stall <= rx_cycle[0];
        endcase
      end
    end
  end

  // Monitor: each accepted token word against the oldest prediction.
  jst_word_t want;

  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("token word with none expected: event_res %0d, payload_byte %0d",
               event_res, payload_byte);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (event_res !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, event_res);
          fail_count++;
        end
        if (payload_byte !== want.payload) begin
          $error("payload_byte: expected %0d, got %0d", want.payload, payload_byte);
          fail_count++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((text_valid && !text_stall) || (token_valid && !token_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("json_stream_tokenizer verification failed");
      $finish;
    end
  end

  initial begin
    // Directed opening: escapes, number corners, keywords, every punctuation.
    put_byte(CH_QUOTE);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_text("\\\"\\\\\"\"");
    put_text("-}.9.,");
    put_text("f[true:false,null{]-0");
    put_end();
    put_byte(CH_QUOTE);
    put_end();
    put_text("fa");
    put_end();

    // Random documents: mostly well formed, the rest loose fragments.
    while (busy_words < TEXT_WORDS) begin
      if ($urandom_range(0, 2) != 0) begin
        put_space();
        gen_value(0);
        put_space();
      end else begin
        repeat ($urandom_range(1, 12)) begin
          gen_fragment();
        end
      end
      if ($urandom_range(0, 5) != 0) begin
        put_end();
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (text_backlog.size() > 0 || text_valid) @(posedge clk);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("json_stream_tokenizer verification clean");
    end else begin
      $display("json_stream_tokenizer verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/jst_pkg.sv
src/jst_lexer.sv
src/json_stream_tokenizer.sv
bench/json_stream_tokenizer_test.sv
